// File: rtl/core/rbc_pkg.sv
// Shared types and constants of the resampler and bit crusher.
package rbc_pkg;

  localparam int CODE_W    = 12;
  localparam int PHASE_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int QUEUE_DEPTH = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH  = 1'b1;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd33554432;

  // scale 127 = (1 << 7) - 1, scale 2047 = (1 << 11) - 1
  localparam int SHIFT_8BIT  = 7;
  localparam int SHIFT_12BIT = 11;

  typedef enum logic {
    JOB_INTERP = 1'b0,
    JOB_HOLD   = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t kind;
    logic      last;
  } job_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
  } quant_ctl_t;

endpackage

// File: rtl/core/rbc_front.sv
// Input front end: accepts samples, keeps the previous one and classifies jobs.
module rbc_front #(
  parameter int SAMPLE_WIDTH = 18
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_last,
  output logic                           in_ready,
  input  logic                           q_full,
  output logic                           q_push,
  output rbc_pkg::job_ctl_t              q_ctl,
  output logic signed [SAMPLE_WIDTH-1:0] q_prev,
  output logic signed [SAMPLE_WIDTH-1:0] q_cur
);
  import rbc_pkg::*;

  logic                           accept;
  logic                           have_prev_r;
  logic signed [SAMPLE_WIDTH-1:0] prev_r;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // first sample of a buffer that is not also its last gives no job
  assign q_push     = accept && (have_prev_r || in_last);
  assign q_ctl.kind = have_prev_r ? JOB_INTERP : JOB_HOLD;
  assign q_ctl.last = in_last;
  assign q_prev     = prev_r;
  assign q_cur      = in_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_r      <= '0;
    end else if (accept) begin
      if (in_last) begin
        have_prev_r <= 1'b0;
        prev_r      <= '0;
      end else begin
        have_prev_r <= 1'b1;
        prev_r      <= in_sample;
      end
    end
  end

endmodule

// File: rtl/core/rbc_queue.sv
// Small job queue between the front end and the sequencer.
module rbc_queue #(
  parameter int DATA_W = 38,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/rbc_back.sv
// Output sequencer: walks the read position and issues one output per cycle while en is high.
module rbc_back #(
  parameter int SAMPLE_WIDTH    = 18,
  parameter int PHASE_FRAC_BITS = 24,
  parameter int MAX_OUTPUTS     = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic [rbc_pkg::PHASE_W-1:0]       phase_step,
  input  logic                              q_empty,
  input  rbc_pkg::job_ctl_t                 q_ctl,
  input  logic signed [SAMPLE_WIDTH-1:0]    q_prev,
  input  logic signed [SAMPLE_WIDTH-1:0]    q_cur,
  output logic                              q_pop,
  output rbc_pkg::quant_ctl_t               issue,
  output logic [PHASE_FRAC_BITS-1:0]        issue_f,
  output logic signed [SAMPLE_WIDTH-1:0]    issue_a,
  output logic signed [SAMPLE_WIDTH-1:0]    issue_b
);
  import rbc_pkg::*;

  localparam int RP_W  = PHASE_W + 1;
  localparam int CNT_W = $clog2(MAX_OUTPUTS + 1);
  localparam logic [RP_W-1:0] ONE_POS = RP_W'(1) << PHASE_FRAC_BITS;
  localparam logic [RP_W-1:0] TWO_POS = RP_W'(1) << (PHASE_FRAC_BITS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INTERP,
    S_HOLD
  } state_t;

  state_t                         state_r;
  logic [PHASE_W-1:0]             read_pos_r;
  logic [RP_W-1:0]                rp_r;
  logic [CNT_W-1:0]               cnt_r;
  logic                           last_r;
  logic signed [SAMPLE_WIDTH-1:0] prev_r;
  logic signed [SAMPLE_WIDTH-1:0] cur_r;

  logic [RP_W-1:0] rp_nxt;
  logic [RP_W-1:0] rp_wrap;
  logic            below_one;
  logic            cnt_full;
  logic            cnt_last;
  logic            emit;

  assign rp_nxt    = rp_r + {1'b0, phase_step};
  assign below_one = (rp_r < ONE_POS);
  assign rp_wrap   = below_one ? '0 : rp_r - ONE_POS;
  assign cnt_full  = (cnt_r == CNT_W'(MAX_OUTPUTS));
  assign cnt_last  = (cnt_r == CNT_W'(MAX_OUTPUTS - 1));
  assign emit      = (state_r != S_IDLE) && below_one && !cnt_full;
  assign q_pop     = en && (state_r == S_IDLE) && !q_empty;

  // held samples go through the interpolator with both ends equal
  assign issue_f = rp_r[PHASE_FRAC_BITS-1:0];
  assign issue_a = (state_r == S_HOLD) ? cur_r : prev_r;
  assign issue_b = cur_r;

  always_comb begin
    issue.valid = emit;
    case (state_r)
      S_INTERP: issue.last = last_r && (cnt_last || (rp_nxt >= TWO_POS));
      S_HOLD:   issue.last = cnt_last || (rp_nxt >= ONE_POS);
      default:  issue.last = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      read_pos_r <= '0;
      rp_r       <= '0;
      cnt_r      <= '0;
      last_r     <= 1'b0;
    end else if (en) begin
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            prev_r <= q_prev;
            cur_r  <= q_cur;
            last_r <= q_ctl.last;
            cnt_r  <= '0;
            if (q_ctl.kind == JOB_INTERP) begin
              rp_r    <= {1'b0, read_pos_r};
              state_r <= S_INTERP;
            end else begin
              rp_r    <= '0;
              state_r <= S_HOLD;
            end
          end
        end
        S_INTERP: begin
          if (emit) begin
            rp_r  <= rp_nxt;
            cnt_r <= cnt_r + 1'b1;
          end else if (last_r) begin
            rp_r    <= rp_wrap;
            state_r <= S_HOLD;
          end else begin
            read_pos_r <= rp_wrap[PHASE_W-1:0];
            state_r    <= S_IDLE;
          end
        end
        S_HOLD: begin
          if (emit) begin
            rp_r  <= rp_nxt;
            cnt_r <= cnt_r + 1'b1;
          end else begin
            read_pos_r <= '0;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/rbc_quant.sv
// Interpolation and quantizer pipeline with the output register.
module rbc_quant #(
  parameter int SAMPLE_WIDTH    = 18,
  parameter int PHASE_FRAC_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  mode,
  input  rbc_pkg::quant_ctl_t                   issue,
  input  logic [PHASE_FRAC_BITS-1:0]            issue_f,
  input  logic signed [SAMPLE_WIDTH-1:0]        issue_a,
  input  logic signed [SAMPLE_WIDTH-1:0]        issue_b,
  output logic                                  en,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [rbc_pkg::CODE_W-1:0]     out_code,
  output logic                                  out_last
);
  import rbc_pkg::*;

  localparam int F      = PHASE_FRAC_BITS;
  localparam int DIFF_W = SAMPLE_WIDTH + 1;
  localparam int PROD_W = SAMPLE_WIDTH + F + 2;
  localparam int V_W    = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + F + 2;
  localparam int MAG_W  = 16 + F;
  localparam int P_W    = MAG_W + SHIFT_12BIT;
  localparam logic signed [V_W-1:0] FULL = V_W'(1) << (15 + F);
  localparam logic [P_W-1:0] HALF = P_W'(1) << (14 + F);

  logic signed [DIFF_W-1:0]       diff;
  logic signed [PROD_W-1:0]       prod;
  logic signed [V_W-1:0]          v;
  logic signed [V_W-1:0]          v_clamp;
  logic [V_W-1:0]                 v_abs;
  logic [P_W-1:0]                 scaled;
  logic [CODE_W-1:0]              code_mag;

  logic                           v1_r;
  logic                           last1_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [SAMPLE_WIDTH-1:0] base_r;
  logic                           v2_r;
  logic                           last2_r;
  logic                           neg_r;
  logic [MAG_W-1:0]               mag_r;

  // advance the whole pipeline unless a result waits at the output
  assign en = !out_valid || out_ready;

  assign diff = DIFF_W'(issue_b) - DIFF_W'(issue_a);
  assign prod = $signed({1'b0, issue_f}) * diff;

  always_comb begin
    v = (V_W'(base_r) <<< F) + V_W'(prod_r);
    if (v > FULL) begin
      v_clamp = FULL;
    end else if (v < -FULL) begin
      v_clamp = -FULL;
    end else begin
      v_clamp = v;
    end
    v_abs = v_clamp[V_W-1] ? -v_clamp : v_clamp;
  end

  always_comb begin
    if (mode) begin
      scaled = (P_W'(mag_r) << SHIFT_12BIT) - P_W'(mag_r) + HALF;
    end else begin
      scaled = (P_W'(mag_r) << SHIFT_8BIT) - P_W'(mag_r) + HALF;
    end
    code_mag = scaled[P_W-1 -: CODE_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod;
      base_r   <= issue_a;
      last1_r  <= issue.last;
      neg_r    <= v[V_W-1];
      mag_r    <= v_abs[MAG_W-1:0];
      last2_r  <= last1_r;
      out_code <= neg_r ? -code_mag : code_mag;
      out_last <= last2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1_r      <= issue.valid;
      v2_r      <= v1_r;
      out_valid <= v2_r;
    end
  end

endmodule

// File: rtl/core/resample_and_bitcrush.sv
// Top level of the linear-interpolation resampler with bit-depth quantizer.
//
// Usage: samples enter on the in_ channel (valid/ready), one signed Q2.15
// sample per transaction, with in_last on the final sample of a buffer. Each
// input transaction yields zero to MAX_OUTPUTS output transactions on the out_
// channel (valid/ready), each a signed integer code, with out_last on the final
// output of a buffer. cfg_we writes phase_step (index 0, Q8.24 advance per
// output) or bit_depth_mode (index 1); write them only while the block is idle.
//
// Timing: the front end accepts a sample and passes a job through a two-entry
// queue. The sequencer loads a job from its idle state, issues one output per
// cycle while the back end is not frozen, and closes each phase in a state step
// of its own. The interpolator and quantizer register the product, the clamped
// magnitude and the rounded code in turn (multiply, clamp, scale and round). A
// first sample of a longer buffer gives no job.
//
// Reset clears the previous sample, the read position, the queue and all valid
// flags; no clearing pass is needed. When the receiver stalls, the output
// register holds its transaction and the whole back end freezes; the front end
// keeps accepting until the queue fills.
module resample_and_bitcrush #(
  parameter int SAMPLE_WIDTH    = 18,
  parameter int PHASE_FRAC_BITS = 24,
  parameter int MAX_OUTPUTS     = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rbc_pkg::CODE_W-1:0]   out_code,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [rbc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rbc_pkg::PHASE_W-1:0]         cfg_wdata
);
  import rbc_pkg::*;

  localparam int CTL_W = $bits(job_ctl_t);
  localparam int JOB_W = CTL_W + 2 * SAMPLE_WIDTH;

  logic [PHASE_W-1:0]             phase_step_r;
  logic                           bit_depth_r;

  job_ctl_t                       f_ctl;
  logic signed [SAMPLE_WIDTH-1:0] f_prev;
  logic signed [SAMPLE_WIDTH-1:0] f_cur;
  logic                           q_push;
  logic                           q_full;
  logic                           q_pop;
  logic                           q_empty;
  logic [JOB_W-1:0]               q_wdata;
  logic [JOB_W-1:0]               q_rdata;
  job_ctl_t                       b_ctl;
  logic signed [SAMPLE_WIDTH-1:0] b_prev;
  logic signed [SAMPLE_WIDTH-1:0] b_cur;

  quant_ctl_t                     issue;
  logic [PHASE_FRAC_BITS-1:0]     issue_f;
  logic signed [SAMPLE_WIDTH-1:0] issue_a;
  logic signed [SAMPLE_WIDTH-1:0] issue_b;
  logic                           en;

  // configuration registers: only bit 0 of the mode word is kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_RESET;
      bit_depth_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_STEP: phase_step_r <= cfg_wdata;
        REG_BIT_DEPTH:  bit_depth_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  rbc_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_sample (in_sample),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ctl     (f_ctl),
    .q_prev    (f_prev),
    .q_cur     (f_cur)
  );

  // pack the job: control word, previous sample, current sample
  assign q_wdata = {f_ctl, f_prev, f_cur};
  assign b_ctl   = job_ctl_t'(q_rdata[JOB_W-1 -: CTL_W]);
  assign b_prev  = q_rdata[2*SAMPLE_WIDTH-1 -: SAMPLE_WIDTH];
  assign b_cur   = q_rdata[SAMPLE_WIDTH-1:0];

  rbc_queue #(
    .DATA_W (JOB_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  rbc_back #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
    .MAX_OUTPUTS     (MAX_OUTPUTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .phase_step (phase_step_r),
    .q_empty    (q_empty),
    .q_ctl      (b_ctl),
    .q_prev     (b_prev),
    .q_cur      (b_cur),
    .q_pop      (q_pop),
    .issue      (issue),
    .issue_f    (issue_f),
    .issue_a    (issue_a),
    .issue_b    (issue_b)
  );

  rbc_quant #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_quant (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (bit_depth_r),
    .issue     (issue),
    .issue_f   (issue_f),
    .issue_a   (issue_a),
    .issue_b   (issue_b),
    .en        (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_code  (out_code),
    .out_last  (out_last)
  );

endmodule

// File: rtl/core/rbc_checker.sv
// Port-level checks of the resampler, bound to the top level.
module rbc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [rbc_pkg::CODE_W-1:0] out_code,
  input logic                              out_last,
  input logic                              cfg_we,
  input logic [rbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [rbc_pkg::PHASE_W-1:0]       cfg_wdata
);
  import rbc_pkg::*;

  logic mode_r;

  // track the mode as written through the port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we && (cfg_index == REG_BIT_DEPTH)) begin
      mode_r <= cfg_wdata[0];
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code) && $stable(out_last))
    else $error("output transaction changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_range_8bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !mode_r |-> (out_code <= 12'sd127) && (out_code >= -12'sd127))
    else $error("code outside 8-bit range");

  a_range_12bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_code != -12'sd2048))
    else $error("code outside 12-bit range");

endmodule

bind resample_and_bitcrush rbc_checker u_rbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_code  (out_code),
  .out_last  (out_last),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata)
);

// File: test/testbench.sv
// Self-checking testbench for the resampler and bit crusher: directed edges, random buffers.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rbc_pkg::*;

  localparam int SAMPLE_W      = 18;
  localparam int FRAC_W        = 24;
  localparam int MAX_OUT       = 8;
  localparam int IDLE_PCT      = 27;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 80;

  localparam longint UNIT_POS   = longint'(1) << FRAC_W;
  localparam longint FULL_SCALE = longint'(1) << (15 + FRAC_W);
  localparam longint HALF_LSB   = longint'(1) << (14 + FRAC_W);
  localparam longint SCALE_8BIT  = (longint'(1) << SHIFT_8BIT) - 1;
  localparam longint SCALE_12BIT = (longint'(1) << SHIFT_12BIT) - 1;

  localparam logic [PHASE_W-1:0] STEP_MIN  = 32'd2097152;
  localparam logic [PHASE_W-1:0] STEP_MAX  = 32'hFFFF_FFFF;
  localparam logic [PHASE_W-1:0] STEP_HALF = 32'd8388608;
  localparam logic [PHASE_W-1:0] STEP_UNIT = 32'd16777216;
  localparam logic [PHASE_W-1:0] STEP_FINE = 32'h0400_0000;

  // bit 0 selects the depth; upper bits are don't-care to the block
  localparam logic [PHASE_W-1:0] MODE_8BIT       = 32'd0;
  localparam logic [PHASE_W-1:0] MODE_12BIT      = 32'd1;
  localparam logic [PHASE_W-1:0] MODE_8BIT_NOISY  = 32'hFFFF_FFFE;
  localparam logic [PHASE_W-1:0] MODE_12BIT_NOISY = 32'hFFFF_FFFF;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MOST_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } level_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_last;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [CODE_W-1:0]   out_code;
  logic                       out_last;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [PHASE_W-1:0]         cfg_wdata;

  // predictor copy of the registers and of the resampler state
  logic [PHASE_W-1:0] phase_advance = PHASE_STEP_RESET;
  logic               wide_mode     = 1'b0;
  longint             held_sample   = 0;
  logic               held_valid    = 1'b0;
  longint             read_pos      = 0;

  // codes still owed by the block, oldest first
  level_t pending_levels[$];

  int   fault_count   = 0;
  int   cycle_count   = 0;
  int   stall_request = 0;
  logic idling_on     = 1'b1;

  resample_and_bitcrush u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_code  (out_code),
    .out_last  (out_last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp to full scale, scale by the selected depth and round half away from zero.
  // The argument carries 15 + FRAC_W fraction bits.
  function automatic logic [CODE_W-1:0] crush_level(longint v);
    longint scale;
    longint mag;
    logic   neg;
    scale = wide_mode ? SCALE_12BIT : SCALE_8BIT;
    neg = v < 0;
    if (v > FULL_SCALE) v = FULL_SCALE;
    if (v < -FULL_SCALE) v = -FULL_SCALE;
    mag = neg ? -v : v;
    mag = (mag * scale + HALF_LSB) >>> (15 + FRAC_W);
    if (neg) mag = -mag;
    return mag[CODE_W-1:0];
  endfunction

  // Work out every code one accepted sample releases, and advance the state.
  function automatic void predict_levels(logic signed [SAMPLE_W-1:0] s, logic is_last);
    longint cur;
    longint pos;
    level_t lv;
    level_t batch[$];
    cur = s;
    pos = read_pos;
    if (held_valid) begin
      // positions between the held sample and this one interpolate
      while (pos < UNIT_POS && batch.size() < MAX_OUT) begin
        lv.code = crush_level(held_sample * UNIT_POS + pos * (cur - held_sample));
        lv.last = 1'b0;
        batch.push_back(lv);
        pos += longint'(phase_advance);
      end
      // cap hit: restart exactly on the current sample
      if (pos < UNIT_POS) pos = UNIT_POS;
      pos -= UNIT_POS;
    end
    if (is_last) begin
      // positions short of the buffer end repeat the final sample
      while (pos < UNIT_POS && batch.size() < MAX_OUT) begin
        lv.code = crush_level(cur * UNIT_POS);
        lv.last = 1'b0;
        batch.push_back(lv);
        pos += longint'(phase_advance);
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      held_sample = 0;
      held_valid  = 1'b0;
      read_pos    = 0;
    end else begin
      held_sample = cur;
      held_valid  = 1'b1;
      read_pos    = pos;
    end
    foreach (batch[i]) pending_levels.push_back(batch[i]);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(9))
      0: s = SAMPLE_MOST_NEG;
      1: s = SAMPLE_MOST_POS;
      2: s = SAMPLE_W'($urandom_range(32832, 32704));
      3: s = SAMPLE_W'(-$urandom_range(32832, 32704));
      4: begin
        s = SAMPLE_W'($urandom_range(256));
        s = s - 128;
      end
      default: s = SAMPLE_W'($urandom());
    endcase
    return s;
  endfunction

  function automatic logic [PHASE_W-1:0] random_step();
    logic [PHASE_W-1:0] step;
    case ($urandom_range(6))
      0: step = STEP_MIN;
      1: step = STEP_MAX;
      2: step = STEP_UNIT;
      3, 4: step = $urandom_range(STEP_FINE, STEP_MIN);
      5: step = $urandom_range(STEP_UNIT, STEP_MIN);
      default: step = $urandom_range(STEP_MAX, STEP_MIN);
    endcase
    return step;
  endfunction

  // Offer one sample, idling first at random; leave valid high on return so
  // that a following call hands over the next transaction without a gap.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic is_last);
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    in_last   <= is_last;
    do @(posedge clk); while (!in_ready);
    predict_levels(s, is_last);
  endtask

  // Send random buffers of one to ten samples, the final one flagged.
  task automatic send_buffers(input int items);
    int left;
    int len;
    left = items;
    while (left > 0) begin
      len = $urandom_range(10, 1);
      for (int k = 0; k < len && left > 0; k++) begin
        send_sample(random_sample(), k == len - 1);
        left--;
      end
    end
  endtask

  // Drop valid, wait for every owed code, then let any silent job finish.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the step register and then the mode register; only while the block is idle.
  task automatic write_config(input logic [PHASE_W-1:0] step,
                              input logic [PHASE_W-1:0] mode_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PHASE_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    phase_advance = step;
    cfg_index <= REG_BIT_DEPTH;
    cfg_wdata <= mode_word;
    @(posedge clk);
    wide_mode = mode_word[0];
    cfg_we <= 1'b0;
  endtask

  // Field extremes, rounding ties, output cap, buffer end with and without
  // a result, first sample of a buffer, large step and the unused mode bits.
  task automatic test_directed_edges();
    // reset settings: step 2.0, 8-bit codes; clamp at both rails
    send_sample(18'sd0, 1'b0);
    send_sample(SAMPLE_MOST_POS, 1'b0);
    send_sample(SAMPLE_MOST_NEG, 1'b0);
    send_sample(18'sd32767, 1'b0);
    send_sample(-18'sd32768, 1'b1);
    drain_block();
    // half step lands exactly on ties: 63.5 and -63.5
    write_config(STEP_HALF, MODE_8BIT);
    send_sample(18'sd0, 1'b0);
    send_sample(18'sd32768, 1'b0);
    send_sample(18'sd0, 1'b0);
    send_sample(-18'sd32768, 1'b0);
    send_sample(18'sd1, 1'b1);
    drain_block();
    // smallest step: eight outputs per interval, tail dropped at the cap
    write_config(STEP_MIN, MODE_12BIT_NOISY);
    send_sample(SAMPLE_MOST_NEG, 1'b0);
    send_sample(SAMPLE_MOST_POS, 1'b0);
    send_sample(18'sd12345, 1'b1);
    send_sample(18'sd777, 1'b1);
    drain_block();
    // largest step: later intervals and the buffer end stay silent
    write_config(STEP_MAX, MODE_8BIT_NOISY);
    send_sample(18'sd1000, 1'b0);
    send_sample(-18'sd1000, 1'b0);
    send_sample(18'sd5, 1'b0);
    send_sample(18'sd6, 1'b1);
    drain_block();
    // just over one sample per output in 12-bit mode
    write_config(STEP_UNIT + 1, MODE_12BIT);
    send_sample(SAMPLE_MOST_POS, 1'b1);
    send_sample(-18'sd5, 1'b0);
    send_sample(18'sd20000, 1'b1);
    drain_block();
  endtask

  task automatic test_random_settings();
    repeat (5) begin
      write_config(random_step(), $urandom());
      send_buffers(28);
      drain_block();
    end
  endtask

  // Stall the receiver long enough for the queue to fill and in_ready to drop.
  task automatic test_receiver_hold();
    write_config(STEP_MIN, MODE_12BIT);
    stall_request = HOLD_CYCLES;
    send_buffers(20);
    drain_block();
  endtask

  // Run both sides flat out for a stretch.
  task automatic test_steady_stream();
    idling_on = 1'b0;
    write_config(random_step(), $urandom());
    send_buffers(30);
    drain_block();
    idling_on = 1'b1;
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin : receiver
    int hold;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request > 0) begin
        hold = stall_request;
        stall_request = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        out_ready <= !idling_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each accepted result with the oldest owed code.
  always @(posedge clk) begin : result_check
    level_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result: code %0d last %0b", out_code, out_last);
      end else begin
        want = pending_levels.pop_front();
        if (out_code !== want.code || out_last !== want.last) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: expected code %0d last %0b, got code %0d last %0b",
                     $signed(want.code), want.last, out_code, out_last);
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin : main
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;
    in_last   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_PHASE_STEP;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_random_settings();
    test_receiver_hold();
    test_steady_stream();
    drain_block();

    if (fault_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
